// File: rtl/nwd_pkg.sv
package nwd_pkg;

  localparam int MAX_SAMPLES  = 256;
  localparam int MAX_TAPS     = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int RESULT_DEPTH = MAX_SAMPLES + MAX_SAMPLES / 8 + MAX_SAMPLES / 16
                                + MAX_SAMPLES / 16 + 8;

  typedef enum logic [1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_LOWPASS  = 2'd1,
    MODE_HIGHPASS = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  localparam logic [2:0] REG_SIGNAL_LENGTH = 3'd0;
  localparam logic [2:0] REG_LOWPASS_TAPS  = 3'd1;
  localparam logic [2:0] REG_HIGHPASS_TAPS = 3'd2;
  localparam logic [2:0] REG_LEVEL1_LENGTH = 3'd3;
  localparam logic [2:0] REG_LEVEL2_LENGTH = 3'd4;
  localparam logic [2:0] REG_LEVEL3_LENGTH = 3'd5;
  localparam logic [2:0] REG_LEVEL4_LENGTH = 3'd6;
  localparam logic [2:0] REG_LEVEL5_LENGTH = 3'd7;

  localparam logic [2:0] SEC_NORM = 3'd0;
  localparam logic [2:0] SEC_D3   = 3'd1;
  localparam logic [2:0] SEC_D4   = 3'd2;
  localparam logic [2:0] SEC_A5   = 3'd3;
  localparam logic [2:0] SEC_D5   = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FLAT  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [2:0] LAST_LEVEL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MM,
    ST_RANGE,
    ST_NRD,
    ST_NWAIT,
    ST_NDIV,
    ST_NWR,
    ST_LVSTART,
    ST_FIR,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/nwd_div.sv
module nwd_div
  import nwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [16:0] divisor,
  output div_ctl_t    ctl,
  output logic [16:0] quotient
);

  // restoring divide, one quotient bit per cycle; quotient known < 2^17
  logic [16:0] rem;
  logic [16:0] dsr;
  logic [16:0] sh;
  logic [4:0]  cnt;
  logic        running;
  logic        done;
  logic [17:0] trial;
  logic        qbit;

  always_comb begin
    trial = {rem, sh[16]};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd16) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend[32:17]};
      sh  <= dividend[16:0];
      dsr <= divisor;
    end else if (running) begin
      rem <= qbit ? 17'(trial - {1'b0, dsr}) : trial[16:0];
      sh  <= {sh[15:0], qbit};
    end
  end

  assign ctl.start = start;
  assign ctl.done  = done;
  assign quotient  = sh;

endmodule

// File: rtl/normalize_and_wavelet_decompose_unit.sv
// Normalizer and five-level wavelet decomposer. Items are taken when start is
// high and busy is low; there is no back-pressure on results: every result is
// shown for exactly one cycle with result_valid high and must be caught then.
// Coefficient writes (mode 1/2) and samples without sample_last give no
// result and leave the unit idle. A read (mode 3) gives its result in the
// cycle after it is taken, and reads may follow each other every cycle. The
// sample carrying sample_last starts the window computation; busy stays high
// until the completion beat. The computation runs a min/max scan over the
// window, then normalizes each sample with the shared 17-step restoring
// divider (skipped for a flat window), then runs every filter output through
// the one shared 24x16 multiply-accumulate: the lowpass outputs of all five
// levels and the highpass outputs of levels three to five.
module normalize_and_wavelet_decompose_unit
  import nwd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [15:0] data_value,
  input  logic [8:0]         word_index,
  input  logic               sample_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output logic               result_valid,
  output logic signed [23:0] result_value,
  output logic [2:0]         section,
  output logic [1:0]         status,
  output logic               final_word
);

  // configuration registers
  logic [8:0] reg_len;
  logic [3:0] reg_lot;
  logic [3:0] reg_hit;
  logic [7:0] reg_l1;
  logic [6:0] reg_l2;
  logic [5:0] reg_l3;
  logic [4:0] reg_l4;
  logic [3:0] reg_l5;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_len <= 9'd256;
      reg_lot <= 4'd8;
      reg_hit <= 4'd8;
      reg_l1  <= 8'd128;
      reg_l2  <= 7'd64;
      reg_l3  <= 6'd32;
      reg_l4  <= 5'd16;
      reg_l5  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIGNAL_LENGTH: reg_len <= cfg_data;
        REG_LOWPASS_TAPS:  reg_lot <= cfg_data[3:0];
        REG_HIGHPASS_TAPS: reg_hit <= cfg_data[3:0];
        REG_LEVEL1_LENGTH: reg_l1  <= cfg_data[7:0];
        REG_LEVEL2_LENGTH: reg_l2  <= cfg_data[6:0];
        REG_LEVEL3_LENGTH: reg_l3  <= cfg_data[5:0];
        REG_LEVEL4_LENGTH: reg_l4  <= cfg_data[4:0];
        REG_LEVEL5_LENGTH: reg_l5  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped lengths and section ends, latched at computation start
  logic [8:0] cn, h0, c1, c2, c3, c4, c5;
  logic [8:0] h1, h2, h3, h4;
  logic [3:0] clo, chi;

  always_comb begin
    if (reg_len == 9'd0) cn = 9'd1;
    else if (reg_len > 9'(MAX_SAMPLES)) cn = 9'(MAX_SAMPLES);
    else cn = reg_len;
    h0 = 9'((10'(cn) + 10'd1) >> 1);
    c1 = ({1'b0, reg_l1} > h0) ? h0 : {1'b0, reg_l1};
    h1 = 9'((10'(c1) + 10'd1) >> 1);
    c2 = ({2'b0, reg_l2} > h1) ? h1 : {2'b0, reg_l2};
    h2 = 9'((10'(c2) + 10'd1) >> 1);
    c3 = ({3'b0, reg_l3} > h2) ? h2 : {3'b0, reg_l3};
    h3 = 9'((10'(c3) + 10'd1) >> 1);
    c4 = ({4'b0, reg_l4} > h3) ? h3 : {4'b0, reg_l4};
    h4 = 9'((10'(c4) + 10'd1) >> 1);
    c5 = ({5'b0, reg_l5} > h4) ? h4 : {5'b0, reg_l5};
    clo = (reg_lot > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : reg_lot;
    chi = (reg_hit > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : reg_hit;
  end

  logic [8:0] n_len;
  logic [3:0] lo_taps, hi_taps;
  logic [7:0] lvl_len [5];
  logic [8:0] sec_end [5];
  logic       flat;

  // storage
  logic signed [15:0] s_mem [MAX_SAMPLES];
  logic signed [23:0] ap_a [MAX_SAMPLES];
  logic signed [23:0] ap_b [MAX_SAMPLES];
  logic signed [23:0] res_mem [RESULT_DEPTH];
  logic signed [15:0] lpc [MAX_TAPS];
  logic signed [15:0] hpc [MAX_TAPS];

  state_t state, state_next;

  logic [8:0] scnt;
  logic [8:0] cnt;
  logic       mm_v, mm_first;
  logic signed [15:0] mn, mx;
  logic [15:0] range_r;
  logic        neg;
  logic [2:0]  lvi;
  logic [7:0]  idx_i;
  logic        hp;
  logic [3:0]  k;
  logic        p1_v, p2_v;
  logic signed [15:0] coef_r;
  logic signed [39:0] prod;
  logic signed [43:0] acc;
  logic        out_use;

  logic accept;
  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // sample memory
  logic               s_re;
  logic [7:0]         s_raddr;
  logic signed [15:0] s_q;

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_SAMPLE && scnt < 9'(MAX_SAMPLES))
      s_mem[scnt[7:0]] <= data_value;
    if (s_re)
      s_q <= s_mem[s_raddr];
  end

  // divider
  logic [32:0] div_dividend;
  logic [16:0] div_divisor;
  logic [16:0] div_q;
  logic        div_start;
  div_ctl_t    div_ctl;

  nwd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .ctl      (div_ctl),
    .quotient (div_q)
  );

  // normalization front end: num = 2*(x-min) - range
  logic signed [16:0] diff;
  logic signed [17:0] num;
  logic [15:0]        mag;

  always_comb begin
    diff = 17'({s_q[15], s_q} - {mn[15], mn});
    num  = 18'($signed({diff, 1'b0}) - $signed({2'b0, range_r}));
    mag  = num[17] ? 16'(-num) : num[15:0];
    div_dividend = {1'b0, mag, 16'b0} + {17'b0, range_r};
    div_divisor  = {range_r, 1'b0};
  end

  logic signed [15:0] norm16;
  logic signed [23:0] norm24;

  always_comb begin
    if (flat) norm16 = '0;
    else if (neg) norm16 = (div_q >= 17'd32768) ? 16'sh8000 : 16'(-div_q[15:0]);
    else norm16 = (div_q > 17'd32767) ? 16'sh7fff : div_q[15:0];
    norm24 = {{8{norm16[15]}}, norm16};
  end

  // filter datapath
  logic [8:0]  t_idx;
  logic [8:0]  t1;
  logic [3:0]  tp;
  logic [3:0]  nterms;
  logic [7:0]  ap_raddr;
  logic signed [23:0] ap_a_q, ap_b_q, src_q;

  always_comb begin
    t_idx    = {idx_i, 1'b0};
    t1       = t_idx + 9'd1;
    tp       = hp ? hi_taps : lo_taps;
    nterms   = ({5'b0, tp} <= t1) ? tp : t1[3:0];
    ap_raddr = 8'(t_idx - {5'b0, k});
    src_q    = lvi[0] ? ap_b_q : ap_a_q;
  end

  logic signed [43:0] rsum;
  logic signed [28:0] rsh;
  logic signed [23:0] fval;

  always_comb begin
    rsum = acc + 44'sd16384;
    rsh  = rsum[43:15];
    if (!((&rsh[28:23]) || (~|rsh[28:23])))
      fval = rsh[28] ? 24'sh800000 : 24'sh7fffff;
    else
      fval = rsh[23:0];
  end

  // write control for the working stores
  logic               ap_a_we, ap_b_we;
  logic [7:0]         ap_waddr;
  logic signed [23:0] ap_wdata;
  logic               res_we;
  logic [8:0]         res_waddr;
  logic signed [23:0] res_wdata;
  logic [8:0]         d_base;

  always_comb begin
    case (lvi)
      3'd2:    d_base = sec_end[0];
      3'd3:    d_base = sec_end[1];
      default: d_base = sec_end[3];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ap_a_we) ap_a[ap_waddr] <= ap_wdata;
    if (ap_b_we) ap_b[ap_waddr] <= ap_wdata;
    ap_a_q <= ap_a[ap_raddr];
    ap_b_q <= ap_b[ap_raddr];
  end

  // read path
  logic               rd_ok;
  logic [2:0]         rd_sec;
  logic signed [23:0] res_q;

  always_comb begin
    rd_ok = (word_index < sec_end[4]);
    if (word_index < sec_end[0]) rd_sec = SEC_NORM;
    else if (word_index < sec_end[1]) rd_sec = SEC_D3;
    else if (word_index < sec_end[2]) rd_sec = SEC_D4;
    else if (word_index < sec_end[3]) rd_sec = SEC_A5;
    else rd_sec = SEC_D5;
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    if (accept && mode == MODE_READ && rd_ok) res_q <= res_mem[word_index];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept && mode == MODE_SAMPLE && sample_last) state_next = ST_SETUP;
      ST_SETUP:   state_next = ST_MM;
      ST_MM:      if (cnt == n_len && !mm_v) state_next = ST_RANGE;
      ST_RANGE:   state_next = ST_NRD;
      ST_NRD:     state_next = ST_NWAIT;
      ST_NWAIT:   state_next = flat ? ST_NWR : ST_NDIV;
      ST_NDIV:    if (div_ctl.done) state_next = ST_NWR;
      ST_NWR:     state_next = (cnt + 9'd1 == n_len) ? ST_LVSTART : ST_NRD;
      ST_LVSTART: begin
        if ({1'b0, idx_i} == {1'b0, lvl_len[lvi]})
          state_next = (lvi == LAST_LEVEL) ? ST_DONE : ST_LVSTART;
        else
          state_next = ST_FIR;
      end
      ST_FIR:     if (k == nterms && !p1_v && !p2_v) state_next = ST_FIN;
      ST_FIN:     state_next = ST_LVSTART;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_re      = 1'b0;
    s_raddr   = cnt[7:0];
    div_start = 1'b0;
    ap_a_we   = 1'b0;
    ap_b_we   = 1'b0;
    ap_waddr  = cnt[7:0];
    ap_wdata  = norm24;
    res_we    = 1'b0;
    res_waddr = cnt;
    res_wdata = norm24;
    case (state)
      ST_MM:    s_re = (cnt < n_len);
      ST_NRD:   s_re = 1'b1;
      ST_NWAIT: div_start = !flat;
      ST_NWR: begin
        ap_a_we = 1'b1;
        res_we  = 1'b1;
      end
      ST_FIN: begin
        ap_waddr  = idx_i;
        ap_wdata  = fval;
        res_wdata = fval;
        if (!hp) begin
          ap_a_we = lvi[0];
          ap_b_we = !lvi[0];
          res_we  = (lvi == LAST_LEVEL);
          res_waddr = sec_end[2] + {1'b0, idx_i};
        end else begin
          res_we    = 1'b1;
          res_waddr = d_base + {1'b0, idx_i};
        end
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      scnt    <= '0;
      flat    <= 1'b0;
      for (int j = 0; j < 5; j++) sec_end[j] <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      // read beats and the completion beat never coincide: reads need idle
      result_valid <= (accept && mode == MODE_READ) || (state == ST_DONE);
      if (accept && mode == MODE_SAMPLE && scnt < 9'(MAX_SAMPLES))
        scnt <= scnt + 9'd1;
      case (state)
        ST_SETUP: begin
          sec_end[0] <= cn;
          sec_end[1] <= cn + c3;
          sec_end[2] <= cn + c3 + c4;
          sec_end[3] <= cn + c3 + c4 + c5;
          sec_end[4] <= cn + c3 + c4 + c5 + c5;
        end
        ST_RANGE: flat <= (mx == mn);
        ST_DONE:  scnt <= '0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_LOWPASS && word_index < 9'(MAX_TAPS))
      lpc[word_index[2:0]] <= data_value;
    if (accept && mode == MODE_HIGHPASS && word_index < 9'(MAX_TAPS))
      hpc[word_index[2:0]] <= data_value;
    if (accept && mode == MODE_READ) begin
      out_use  <= rd_ok;
      section  <= rd_ok ? rd_sec : SEC_NORM;
      status   <= rd_ok ? (flat ? STATUS_FLAT : STATUS_OK) : STATUS_RANGE;
      final_word <= rd_ok && ({1'b0, word_index} + 10'd1 == {1'b0, sec_end[4]});
    end
    case (state)
      ST_SETUP: begin
        n_len      <= cn;
        lo_taps    <= clo;
        hi_taps    <= chi;
        lvl_len[0] <= c1[7:0];
        lvl_len[1] <= c2[7:0];
        lvl_len[2] <= c3[7:0];
        lvl_len[3] <= c4[7:0];
        lvl_len[4] <= c5[7:0];
        cnt        <= '0;
        mm_v       <= 1'b0;
        mm_first   <= 1'b1;
      end
      ST_MM: begin
        if (cnt < n_len) cnt <= cnt + 9'd1;
        mm_v <= (cnt < n_len);
        if (mm_v) begin
          mm_first <= 1'b0;
          if (mm_first || s_q < mn) mn <= s_q;
          if (mm_first || s_q > mx) mx <= s_q;
        end
      end
      ST_RANGE: begin
        range_r <= 16'(17'({mx[15], mx} - {mn[15], mn}));
        cnt     <= '0;
      end
      ST_NWAIT: neg <= num[17];
      ST_NWR: begin
        cnt   <= cnt + 9'd1;
        lvi   <= '0;
        idx_i <= '0;
        hp    <= 1'b0;
      end
      ST_LVSTART: begin
        if ({1'b0, idx_i} == {1'b0, lvl_len[lvi]}) begin
          idx_i <= '0;
          if (lvi != LAST_LEVEL) lvi <= lvi + 3'd1;
        end else begin
          acc  <= '0;
          k    <= '0;
          p1_v <= 1'b0;
          p2_v <= 1'b0;
        end
      end
      ST_FIR: begin
        if (k < nterms) begin
          k      <= k + 4'd1;
          coef_r <= hp ? hpc[k[2:0]] : lpc[k[2:0]];
        end
        p1_v <= (k < nterms);
        p2_v <= p1_v;
        prod <= src_q * coef_r;
        if (p2_v) acc <= acc + {{4{prod[39]}}, prod};
      end
      ST_FIN: begin
        if (!hp && lvi >= 3'd2) begin
          hp <= 1'b1;
        end else begin
          hp    <= 1'b0;
          idx_i <= idx_i + 8'd1;
        end
      end
      ST_DONE: begin
        out_use    <= 1'b0;
        section    <= SEC_NORM;
        status     <= flat ? STATUS_FLAT : STATUS_OK;
        final_word <= 1'b1;
      end
      default: ;
    endcase
  end

  assign result_value = out_use ? res_q : '0;

`ifndef SYNTHESIS
  a_done_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (result_valid && final_word && !busy))
    else $error("completion beat missing");

  a_res_addr: assert property (@(posedge clk) disable iff (rst)
    res_we |-> (res_waddr < 9'(RESULT_DEPTH)))
    else $error("result store write out of range");

  a_tap_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIR && k < nterms) |-> ({5'b0, k} <= t_idx))
    else $error("filter tap reaches before window start");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_NDIV))
    else $error("divider started outside normalization");
`endif

endmodule
